// File: src/cfq_pkg.sv
package cfq_pkg;

    // Ring storage
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = $clog2(DEPTH + 1);
    localparam int SIZE_W = 7;
    localparam int CMP_W  = (LEN_W > SIZE_W) ? LEN_W : SIZE_W;
    localparam int DATA_W = 32;

    // Operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_REMOVE = 2'd1;
    localparam logic [1:0] FN_DRAIN  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Source of the result word
    typedef enum logic [1:0] {
        RES_RAM  = 2'd0,
        RES_ZERO = 2'd1,
        RES_NEG1 = 2'd2
    } t_res_sel;

    // Controller to datapath
    typedef struct packed {
        logic       cfg_load;
        logic       wr_en;
        logic       rd_en;
        logic       res_load;
        t_res_sel   res_sel;
        logic [1:0] res_status;
        logic       res_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic nh_is_tail;
        logic res_last;
    } t_stat;

    // Saturate a written size into [2, DEPTH]
    function automatic logic [LEN_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (w < CMP_W'(2)) begin
            return LEN_W'(2);
        end else if (w > CMP_W'(DEPTH)) begin
            return LEN_W'(DEPTH);
        end
        return LEN_W'(w);
    endfunction

endpackage

// File: src/cfq_ram.sv
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/cfq_dpath.sv
module cfq_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cfq_pkg::t_cmd              i_cmd,
    input  logic [cfq_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic [cfq_pkg::DATA_W-1:0] i_value,
    output cfq_pkg::t_stat             o_stat,
    output logic [cfq_pkg::DATA_W-1:0] o_data,
    output logic [1:0]                 o_status,
    output logic                       o_last
);
    import cfq_pkg::*;

    logic [LEN_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [LEN_W-1:0]  cfg_len;
    logic [DATA_W-1:0] rd_data;
    t_res_sel          r_sel;
    logic [1:0]        r_status;
    logic              r_last;

    // Step an index round the ring
    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx,
                                                   input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] n;
        n = LEN_W'(idx) + LEN_W'(1);
        return (n >= len) ? '0 : n[ADDR_W-1:0];
    endfunction

    assign n_head  = advance(r_head, r_len);
    assign n_tail  = advance(r_tail, r_len);
    assign cfg_len = clamp_size(i_cfg_data);

    // Ring length and pointers; a size write empties the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_W'(DEPTH);
            r_head <= ADDR_W'(DEPTH - 1);
            r_tail <= ADDR_W'(DEPTH - 1);
        end else if (i_cmd.cfg_load) begin
            r_len  <= cfg_len;
            r_head <= ADDR_W'(cfg_len - LEN_W'(1));
            r_tail <= ADDR_W'(cfg_len - LEN_W'(1));
        end else begin
            if (i_cmd.wr_en) begin
                r_tail <= n_tail;
            end
            if (i_cmd.rd_en) begin
                r_head <= n_head;
            end
        end
    end

    // Slot store
    cfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (n_tail),
        .i_wr_data (i_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (n_head),
        .o_rd_data (rd_data)
    );

    // Result fields beside the RAM output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_sel    <= i_cmd.res_sel;
            r_status <= i_cmd.res_status;
            r_last   <= i_cmd.res_last;
        end
    end

    always_comb begin
        case (r_sel)
            RES_RAM:  o_data = rd_data;
            RES_ZERO: o_data = '0;
            RES_NEG1: o_data = '1;
            default:  o_data = '0;
        endcase
    end

    assign o_status = r_status;
    assign o_last   = r_last;

    // Status to the controller
    assign o_stat.empty      = (r_head == r_tail);
    assign o_stat.full       = (n_tail == r_head);
    assign o_stat.nh_is_tail = (n_head == r_tail);
    assign o_stat.res_last   = r_last;

endmodule

// File: src/cfq_ctrl.sv
module cfq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_func,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  cfq_pkg::t_stat i_stat,
    output cfq_pkg::t_cmd  o_cmd
);
    import cfq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   in_take;
    logic   out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes: a new beat is taken when idle with no size write waiting, or as the final result leaves
    always_comb begin
        o_cfg_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        out_take    = o_out_valid && i_out_ready;
        unique case (r_state)
            S_IDLE:  o_in_ready = !i_cfg_valid;
            S_OUT:   o_in_ready = i_out_ready && i_stat.res_last;
            default: o_in_ready = 1'b0;
        endcase
        in_take = i_in_valid && o_in_ready;
    end

    // Commands and next state
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_sel    = RES_ZERO;
        o_cmd.res_status = ST_OK;
        o_cmd.cfg_load   = i_cfg_valid && o_cfg_ready;
        n_state          = r_state;

        // Drain in progress: fetch the next entry as this one is taken
        if (out_take && !i_stat.res_last) begin
            o_cmd.rd_en    = 1'b1;
            o_cmd.res_load = 1'b1;
            o_cmd.res_sel  = RES_RAM;
            o_cmd.res_last = i_stat.nh_is_tail;
        end else if (out_take) begin
            n_state = S_IDLE;
        end

        if (in_take) begin
            n_state = S_OUT;
            o_cmd.res_load = 1'b1;
            o_cmd.res_last = 1'b1;
            unique case (i_func) inside
                FN_INSERT: begin
                    o_cmd.res_sel = RES_ZERO;
                    if (i_stat.full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
                FN_REMOVE, FN_DRAIN: begin
                    if (i_stat.empty) begin
                        o_cmd.res_sel    = RES_NEG1;
                        o_cmd.res_status = ST_EMPTY;
                    end else begin
                        o_cmd.rd_en   = 1'b1;
                        o_cmd.res_sel = RES_RAM;
                        if (i_func == FN_DRAIN) begin
                            o_cmd.res_last = i_stat.nh_is_tail;
                        end
                    end
                end
                default: begin
                    // unknown operation: taken and dropped
                    o_cmd.res_load = 1'b0;
                    n_state        = S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/circular_fifo_queue_unit.sv
// Channel  Direction  Handshake                   Payload
// cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_data (ring size)
// in       in         i_in_valid  / o_in_ready    i_func, i_value
// out      out        o_out_valid / i_out_ready   o_data, o_status, o_last
//
// Insert and remove: the beat is taken, the RAM is written or read at that
// edge, and the result is shown from the next cycle. A drain gives one
// result per cycle while i_out_ready is high; each entry is read from the
// RAM as the previous result is taken. A new input beat is taken in the
// same cycle as the final result of the last one. Reset is synchronous and
// leaves an empty ring of 64 slots; a size write also empties the queue.
module circular_fifo_queue_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cfq_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic signed [31:0]         i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [31:0]         o_data,
    output logic [1:0]                 o_status,
    output logic                       o_last
);
    import cfq_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [DATA_W-1:0] data;

    cfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cfq_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_data (i_cfg_data),
        .i_value    (DATA_W'(i_value)),
        .o_stat     (stat),
        .o_data     (data),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    assign o_data = signed'(data);

endmodule

// File: test/testbench.sv
module testbench;
    import cfq_pkg::*;

    // func value 3 has no operation behind it
    localparam logic [1:0] FN_UNUSED = 2'd3;
    localparam int unsigned RANDOM_OPS = 330;
    localparam int unsigned HOLD_CYCLES = 200;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } t_result;

    typedef enum logic {
        ROW_OP,
        ROW_SIZE
    } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [1:0]         func;
        logic [31:0]        value;
        logic [SIZE_W-1:0]  size;
        bit                 known;
        logic signed [31:0] want_data;
        logic [1:0]         want_status;
    } t_plan_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [SIZE_W-1:0] i_cfg_data  = '0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_func      = FN_INSERT;
    logic signed [31:0] i_value    = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic signed [31:0] o_data;
    logic [1:0]        o_status;
    logic              o_last;

    circular_fifo_queue_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // Clock: period 10
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop if the run hangs
    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    // Shadow ring and expected results
    logic [31:0]  ring_mem [DEPTH];
    int unsigned  rd_ptr;
    int unsigned  wr_ptr;
    int unsigned  ring_len;
    t_result      pending_results [$];
    int unsigned  fails = 0;
    int unsigned  results_taken = 0;
    int unsigned  ops_sent = 0;
    bit           no_gaps = 1'b0;
    t_plan_row    plan [$];

    // A size write saturates into [2, DEPTH] and empties the ring
    function automatic void resize_ring(input logic [SIZE_W-1:0] v);
        int unsigned n;
        n = v;
        if (n < 2) begin
            n = 2;
        end else if (n > DEPTH) begin
            n = DEPTH;
        end
        ring_len = n;
        rd_ptr   = n - 1;
        wr_ptr   = n - 1;
    endfunction

    function automatic int unsigned ring_next(input int unsigned i);
        return (i + 1 >= ring_len) ? 0 : i + 1;
    endfunction

    // Expected results of one accepted beat, appended to pending_results
    function automatic void ring_predict(input logic [1:0] f, input logic [31:0] v);
        int unsigned nxt;
        int unsigned cnt;
        t_result     r;
        case (f)
            FN_INSERT: begin
                nxt = ring_next(wr_ptr);
                r = '{data: '0, status: ST_OK, last: 1'b1};
                if (nxt == rd_ptr) begin
                    r.status = ST_FULL;
                end else begin
                    wr_ptr = nxt;
                    ring_mem[nxt] = v;
                end
                pending_results.push_back(r);
            end
            FN_REMOVE: begin
                if (rd_ptr == wr_ptr) begin
                    r = '{data: -32'sd1, status: ST_EMPTY, last: 1'b1};
                end else begin
                    rd_ptr = ring_next(rd_ptr);
                    r = '{data: ring_mem[rd_ptr], status: ST_OK, last: 1'b1};
                end
                pending_results.push_back(r);
            end
            FN_DRAIN: begin
                if (rd_ptr == wr_ptr) begin
                    r = '{data: -32'sd1, status: ST_EMPTY, last: 1'b1};
                    pending_results.push_back(r);
                end else begin
                    cnt = 0;
                    while (rd_ptr != wr_ptr && cnt < DEPTH - 1) begin
                        rd_ptr = ring_next(rd_ptr);
                        r = '{data: ring_mem[rd_ptr], status: ST_OK,
                              last: (rd_ptr == wr_ptr)};
                        pending_results.push_back(r);
                        cnt++;
                    end
                end
            end
            default: begin
                // ignored: no result, nothing moves
            end
        endcase
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small rings, with the extremes now and then
    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd2;
            3:       return 7'd63;
            4:       return 7'd64;
            5:       return 7'd65;
            6:       return 7'd127;
            7:       return SIZE_W'($urandom_range(0, 127));
            default: return SIZE_W'($urandom_range(3, 9));
        endcase
    endfunction

    // Stimulus table
    task automatic add_op(input logic [1:0] f, input logic [31:0] v);
        plan.push_back('{kind: ROW_OP, func: f, value: v, size: '0, known: 1'b0,
                         want_data: '0, want_status: ST_OK});
    endtask

    task automatic add_known(input logic [1:0] f, input logic [31:0] v,
                             input logic [31:0] d, input logic [1:0] s);
        plan.push_back('{kind: ROW_OP, func: f, value: v, size: '0, known: 1'b1,
                         want_data: d, want_status: s});
    endtask

    task automatic add_size(input logic [SIZE_W-1:0] s);
        plan.push_back('{kind: ROW_SIZE, func: FN_INSERT, value: '0, size: s,
                         known: 1'b0, want_data: '0, want_status: ST_OK});
    endtask

    // One input beat, entered at a falling edge, left at a falling edge.
    // With no gap, valid stays high: the caller drives the next beat at once.
    task automatic send_beat(input logic [1:0] f, input logic [31:0] v,
                             input bit known, input t_result want);
        int unsigned before_n;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        before_n = pending_results.size();
        ring_predict(f, v);
        if (known) begin
            while (pending_results.size() > before_n) void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        if (f != FN_UNUSED) ops_sent++;
        @(negedge i_clk);
        gap = no_gaps ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            i_func     <= 2'($urandom);
            i_value    <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_op(input logic [1:0] f, input logic [31:0] v);
        send_beat(f, v, 1'b0, '0);
    endtask

    // Size write once the block has gone quiet
    task automatic write_size(input logic [SIZE_W-1:0] s);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= s;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        resize_ring(s);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                $error("unexpected result: data %0d status %0d last %0d",
                       o_data, o_status, o_last);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (o_data !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, o_data);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fails++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fails++;
                end
            end
        end
    end

    // Result side: random stalls, calm stretches and two long hold-offs
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned holds_done;
        int unsigned r;
        stall_left = 0;
        calm_left  = 0;
        holds_done = 0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (stall_left == 0) begin
                if (holds_done < 2 && results_taken >= 100 + holds_done * 150) begin
                    stall_left = HOLD_CYCLES;
                    holds_done++;
                end else if (calm_left != 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 5) begin
                        calm_left = $urandom_range(40, 120);
                    end else begin
                        stall_left = idle_len();
                    end
                end
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(negedge i_clk);
        end
    end

    // Stimulus
    initial begin
        int unsigned cap;
        int unsigned n;
        int unsigned r;
        logic [1:0]  f;
        t_result     want;
        resize_ring(7'd64);

        // directed rows
        add_known(FN_REMOVE, 32'h0, 32'hFFFF_FFFF, ST_EMPTY);
        add_known(FN_DRAIN, 32'h0, 32'hFFFF_FFFF, ST_EMPTY);
        add_op(FN_UNUSED, 32'hFFFF_FFFF);
        add_known(FN_INSERT, 32'h7FFF_FFFF, 32'h0, ST_OK);
        add_known(FN_INSERT, 32'h8000_0000, 32'h0, ST_OK);
        add_known(FN_INSERT, 32'h0000_0000, 32'h0, ST_OK);
        add_known(FN_INSERT, 32'hFFFF_FFFF, 32'h0, ST_OK);
        add_known(FN_REMOVE, 32'h0, 32'h7FFF_FFFF, ST_OK);
        add_op(FN_DRAIN, 32'h0);
        add_size(7'd2);
        add_known(FN_INSERT, 32'h5A5A_5A5A, 32'h0, ST_OK);
        add_known(FN_INSERT, 32'h0000_0001, 32'h0, ST_FULL);
        add_known(FN_REMOVE, 32'h0, 32'h5A5A_5A5A, ST_OK);
        add_known(FN_REMOVE, 32'h0, 32'hFFFF_FFFF, ST_EMPTY);
        // size 0 behaves as 2
        add_size(7'd0);
        add_known(FN_INSERT, 32'h0000_0003, 32'h0, ST_OK);
        add_known(FN_INSERT, 32'h0000_0004, 32'h0, ST_FULL);
        add_op(FN_DRAIN, 32'h0);
        // above DEPTH saturates
        add_size(7'd127);
        add_op(FN_INSERT, 32'hA5A5_A5A5);
        add_op(FN_DRAIN, 32'h0);
        add_size(7'd3);
        add_op(FN_INSERT, 32'h1234_5678);
        add_op(FN_INSERT, 32'h8765_4321);
        add_known(FN_INSERT, 32'h0000_0005, 32'h0, ST_FULL);
        add_op(FN_DRAIN, 32'h0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_SIZE) begin
                write_size(plan[k].size);
            end else begin
                want = '{data: plan[k].want_data, status: plan[k].want_status,
                         last: 1'b1};
                send_beat(plan[k].func, plan[k].value, plan[k].known, want);
            end
        end

        // random phases: a size write, then a few sequences on that ring
        ops_sent = 0;
        while (ops_sent < RANDOM_OPS) begin
            write_size(pick_size());
            cap = ring_len - 1;
            repeat ($urandom_range(2, 5)) begin
                if (ops_sent >= RANDOM_OPS) break;
                no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    // fill, sometimes past full, then drain
                    n = ($urandom_range(0, 2) == 0) ? cap + $urandom_range(0, 2)
                                                    : $urandom_range(1, cap);
                    repeat (n) send_op(FN_INSERT, pick_word());
                    send_op(FN_DRAIN, $urandom);
                end else if (r < 6) begin
                    // fill, then remove one more than went in
                    n = $urandom_range(1, cap);
                    repeat (n) send_op(FN_INSERT, pick_word());
                    repeat (n + 1) send_op(FN_REMOVE, $urandom);
                end else begin
                    // mixed traffic with some noise
                    repeat ($urandom_range(8, 20)) begin
                        r = $urandom_range(0, 99);
                        if (r < 45) begin
                            f = FN_INSERT;
                        end else if (r < 80) begin
                            f = FN_REMOVE;
                        end else if (r < 93) begin
                            f = FN_DRAIN;
                        end else begin
                            f = FN_UNUSED;
                        end
                        send_op(f, pick_word());
                    end
                end
            end
        end
        no_gaps = 1'b0;

        // let everything come out, then a short tail
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
